/* rtl/htd_pkg.sv */
// Package for the Huffman table decoder: sizes, codes, state and record types.
// Used by the interfaces and the top level.
package htd_pkg;

  localparam int TABLE_ENTRIES   = 256;
  localparam int MAX_CODE_LENGTH = 16;
  localparam int BYTE_BITS       = 8;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int ELEN_W  = 5;
  localparam int ECODE_W = 16;
  localparam int STAT_W  = 2;
  localparam int SIZE_W  = 32;

  localparam int ADDR_W    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int CODE_W    = MAX_CODE_LENGTH;
  localparam int LEN_W     = $clog2(MAX_CODE_LENGTH + 1);
  localparam int BIT_CNT_W = $clog2(BYTE_BITS + 1);

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LONG      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNMATCHED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN_BIT,
    ST_SCAN_LOAD,
    ST_PUSH,
    ST_FLUSH
  } htd_state_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic              finished;
    logic [STAT_W-1:0] status;
  } result_t;

  // sticky status: first nonzero code wins
  function automatic logic [STAT_W-1:0] raise_status(logic [STAT_W-1:0] cur,
                                                     logic [STAT_W-1:0] code);
    raise_status = (cur == STAT_OK) ? code : cur;
  endfunction

endpackage

/* rtl/htd_if.sv */
// Valid/ready channel interfaces of the Huffman table decoder.
// Depends on htd_pkg for field widths.
interface htd_item_if;
  logic                        valid;
  logic                        ready;
  logic [htd_pkg::OP_W-1:0]    operation;
  logic [htd_pkg::SYM_W-1:0]   entry_symbol;
  logic [htd_pkg::ELEN_W-1:0]  entry_length;
  logic [htd_pkg::ECODE_W-1:0] entry_code;
  logic [htd_pkg::SYM_W-1:0]   data_byte;
  modport source(output valid, operation, entry_symbol, entry_length, entry_code, data_byte,
                 input ready);
  modport sink(input valid, operation, entry_symbol, entry_length, entry_code, data_byte,
               output ready);
endinterface

interface htd_result_if;
  logic                       valid;
  logic                       ready;
  logic [htd_pkg::SYM_W-1:0]  symbol;
  logic                       last;
  logic                       finished;
  logic [htd_pkg::STAT_W-1:0] status;
  modport source(output valid, symbol, last, finished, status, input ready);
  modport sink(input valid, symbol, last, finished, status, output ready);
endinterface

interface htd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [htd_pkg::SIZE_W-1:0] data_size;
  modport source(output valid, data_size, input ready);
  modport sink(input valid, data_size, output ready);
endinterface

/* rtl/huffman_table_decoder.sv */
// Huffman table decoder top level: control sequencer, bit shifter, table scan.
// Depends on htd_pkg, htd_if (channel interfaces) and htd_ram (code table).
//
// The code table sits in a RAM with one write port and a registered read
// port and is searched one entry per cycle, in load order, up to the fill
// count; there is no clearing pass, a clear item zeroes the fill count,
// the partial code, the emitted count and the status. A load scans for an
// entry of the same length and code, stops early on a hit and overwrites
// it, else appends the entry unless the table is full. A data byte is
// shifted in one bit at a time, MSB first; each bit is followed by a
// table scan that ends on a hit, when the symbol is handed on, or at the
// fill count; the byte ends with one more bit step and a flush step. The
// push and flush steps wait while the result side stalls. Results
// leave through an output register; the last symbol of a byte is held back
// until the byte is done so that its last flag is known.
module huffman_table_decoder (
  input  logic clk,
  input  logic rst,
  htd_item_if.sink     items,
  htd_result_if.source results,
  htd_cfg_if.sink      cfg
);

  localparam int AW = htd_pkg::ADDR_W;
  localparam int CW = htd_pkg::CNT_W;
  localparam int KW = htd_pkg::CODE_W;
  localparam int LW = htd_pkg::LEN_W;
  localparam int BW = htd_pkg::BYTE_BITS;

  htd_pkg::htd_state_t state, state_next;

  logic [htd_pkg::SIZE_W-1:0] data_size, data_size_next;
  logic [CW-1:0]              entry_count, entry_count_next;
  logic [KW-1:0]              partial_code, partial_code_next;
  logic [LW-1:0]              partial_len, partial_len_next;
  logic [htd_pkg::SIZE_W-1:0] emitted_count, emitted_count_next;
  logic [htd_pkg::STAT_W-1:0] status, status_next;
  logic [CW-1:0]              scan_idx, scan_idx_next;
  logic                       rd_valid, rd_valid_next;
  logic [AW-1:0]              rd_idx, rd_idx_next;
  logic                       pending_valid, pending_valid_next;
  logic                       out_valid, out_valid_next;

  logic [LW-1:0]                key_len, key_len_next;
  logic [KW-1:0]                key_code, key_code_next;
  logic [htd_pkg::SYM_W-1:0]    key_sym, key_sym_next;
  logic [BW-1:0]                shreg, shreg_next;
  logic [htd_pkg::BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  htd_pkg::result_t             hit_res, hit_res_next;
  htd_pkg::result_t             pending, pending_next;
  htd_pkg::result_t             out_res, out_res_next;
  logic                         out_last, out_last_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  htd_pkg::entry_t      ram_wdata;
  htd_pkg::entry_t      ram_rdata;
  logic [KW-1:0]        code_mask;
  logic                 issue;
  logic                 match;
  logic                 out_free;
  logic                 done;
  logic [htd_pkg::SIZE_W-1:0] emitted_inc;

  htd_ram #(
    .WIDTH($bits(htd_pkg::entry_t)),
    .DEPTH(htd_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < KW; i++) begin
      code_mask[i] = (i < int'(items.entry_length));
    end
  end

  assign items.ready      = (state == htd_pkg::ST_IDLE);
  assign cfg.ready        = 1'b1;
  assign results.valid    = out_valid;
  assign results.symbol   = out_res.symbol;
  assign results.last     = out_last;
  assign results.finished = out_res.finished;
  assign results.status   = out_res.status;

  assign issue       = (scan_idx < entry_count);
  assign match       = rd_valid && (ram_rdata.length == key_len) && (ram_rdata.code == key_code);
  assign out_free    = !out_valid || results.ready;
  assign done        = (data_size == '0) || (emitted_count >= data_size);
  assign emitted_inc = emitted_count + 1'b1;

  always_comb begin
    state_next         = state;
    data_size_next     = data_size;
    entry_count_next   = entry_count;
    partial_code_next  = partial_code;
    partial_len_next   = partial_len;
    emitted_count_next = emitted_count;
    status_next        = status;
    scan_idx_next      = scan_idx;
    rd_valid_next      = 1'b0;
    rd_idx_next        = scan_idx[AW-1:0];
    pending_valid_next = pending_valid;
    out_valid_next     = out_valid;
    key_len_next       = key_len;
    key_code_next      = key_code;
    key_sym_next       = key_sym;
    shreg_next         = shreg;
    bit_cnt_next       = bit_cnt;
    hit_res_next       = hit_res;
    pending_next       = pending;
    out_res_next       = out_res;
    out_last_next      = out_last;
    ram_we             = 1'b0;
    ram_waddr          = entry_count[AW-1:0];
    ram_wdata          = '{symbol: key_sym, length: key_len, code: key_code};

    if (cfg.valid) begin
      data_size_next = cfg.data_size;
    end
    if (out_valid && results.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      htd_pkg::ST_IDLE: begin
        if (items.valid) begin
          unique case (items.operation)
            htd_pkg::OP_CLEAR: begin
              entry_count_next   = '0;
              partial_code_next  = '0;
              partial_len_next   = '0;
              emitted_count_next = '0;
              status_next        = htd_pkg::STAT_OK;
            end
            htd_pkg::OP_LOAD: begin
              if (int'(items.entry_length) > htd_pkg::MAX_CODE_LENGTH) begin
                status_next = htd_pkg::raise_status(status, htd_pkg::STAT_LONG);
              end else if (items.entry_length != '0) begin
                key_len_next  = LW'(items.entry_length);
                key_code_next = KW'(items.entry_code) & code_mask;
                key_sym_next  = items.entry_symbol;
                scan_idx_next = '0;
                state_next    = htd_pkg::ST_SCAN_LOAD;
              end
            end
            htd_pkg::OP_DATA: begin
              shreg_next   = items.data_byte;
              bit_cnt_next = htd_pkg::BIT_CNT_W'(BW);
              state_next   = htd_pkg::ST_BIT;
            end
            default: ;
          endcase
        end
      end

      htd_pkg::ST_BIT: begin
        if (done || bit_cnt == '0) begin
          state_next = htd_pkg::ST_FLUSH;
        end else begin
          partial_code_next = {partial_code[KW-2:0], shreg[BW-1]};
          partial_len_next  = partial_len + 1'b1;
          key_code_next     = {partial_code[KW-2:0], shreg[BW-1]};
          key_len_next      = partial_len + 1'b1;
          shreg_next        = {shreg[BW-2:0], 1'b0};
          bit_cnt_next      = bit_cnt - 1'b1;
          scan_idx_next     = '0;
          state_next        = htd_pkg::ST_SCAN_BIT;
        end
      end

      htd_pkg::ST_SCAN_BIT: begin
        if (match) begin
          emitted_count_next    = emitted_inc;
          hit_res_next.symbol   = ram_rdata.symbol;
          hit_res_next.finished = (emitted_inc == data_size);
          hit_res_next.status   = status;
          partial_code_next     = '0;
          partial_len_next      = '0;
          state_next            = htd_pkg::ST_PUSH;
        end else if (!rd_valid && !issue) begin
          if (partial_len == LW'(htd_pkg::MAX_CODE_LENGTH)) begin
            status_next       = htd_pkg::raise_status(status, htd_pkg::STAT_UNMATCHED);
            partial_code_next = '0;
            partial_len_next  = '0;
          end
          state_next = htd_pkg::ST_BIT;
        end else if (issue) begin
          rd_valid_next = 1'b1;
          scan_idx_next = scan_idx + 1'b1;
        end
      end

      htd_pkg::ST_SCAN_LOAD: begin
        if (match) begin
          ram_we     = 1'b1;
          ram_waddr  = rd_idx;
          state_next = htd_pkg::ST_IDLE;
        end else if (!rd_valid && !issue) begin
          if (entry_count == CW'(htd_pkg::TABLE_ENTRIES)) begin
            status_next = htd_pkg::raise_status(status, htd_pkg::STAT_FULL);
          end else begin
            ram_we           = 1'b1;
            entry_count_next = entry_count + 1'b1;
          end
          state_next = htd_pkg::ST_IDLE;
        end else if (issue) begin
          rd_valid_next = 1'b1;
          scan_idx_next = scan_idx + 1'b1;
        end
      end

      htd_pkg::ST_PUSH: begin
        if (!pending_valid) begin
          pending_next       = hit_res;
          pending_valid_next = 1'b1;
          state_next         = htd_pkg::ST_BIT;
        end else if (out_free) begin
          out_res_next   = pending;
          out_last_next  = 1'b0;
          out_valid_next = 1'b1;
          pending_next   = hit_res;
          state_next     = htd_pkg::ST_BIT;
        end
      end

      htd_pkg::ST_FLUSH: begin
        if (!pending_valid) begin
          state_next = htd_pkg::ST_IDLE;
        end else if (out_free) begin
          out_res_next       = pending;
          out_last_next      = 1'b1;
          out_valid_next     = 1'b1;
          pending_valid_next = 1'b0;
          state_next         = htd_pkg::ST_IDLE;
        end
      end

      default: state_next = htd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= htd_pkg::ST_IDLE;
      data_size     <= '0;
      entry_count   <= '0;
      partial_code  <= '0;
      partial_len   <= '0;
      emitted_count <= '0;
      status        <= htd_pkg::STAT_OK;
      scan_idx      <= '0;
      rd_valid      <= 1'b0;
      pending_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      data_size     <= data_size_next;
      entry_count   <= entry_count_next;
      partial_code  <= partial_code_next;
      partial_len   <= partial_len_next;
      emitted_count <= emitted_count_next;
      status        <= status_next;
      scan_idx      <= scan_idx_next;
      rd_valid      <= rd_valid_next;
      pending_valid <= pending_valid_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    key_len  <= key_len_next;
    key_code <= key_code_next;
    key_sym  <= key_sym_next;
    shreg    <= shreg_next;
    bit_cnt  <= bit_cnt_next;
    hit_res  <= hit_res_next;
    pending  <= pending_next;
    out_res  <= out_res_next;
    out_last <= out_last_next;
  end

  a_pending_idle: assert property (@(posedge clk) disable iff (rst)
    state == htd_pkg::ST_IDLE |-> !pending_valid)
    else $error("held symbol left over after a data beat");

  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    (status != htd_pkg::STAT_OK &&
     !(items.valid && items.ready && items.operation == htd_pkg::OP_CLEAR))
    |=> status == $past(status))
    else $error("sticky status changed without a clear");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == htd_pkg::ST_SCAN_BIT || state == htd_pkg::ST_SCAN_LOAD) && match)
    |-> CW'(rd_idx) < entry_count)
    else $error("table hit beyond fill count");

  a_partial_bound: assert property (@(posedge clk) disable iff (rst)
    (state == htd_pkg::ST_IDLE || state == htd_pkg::ST_BIT)
    |-> partial_len < LW'(htd_pkg::MAX_CODE_LENGTH))
    else $error("partial code reached maximum length outside a scan");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(htd_pkg::TABLE_ENTRIES))
    else $error("fill count above table size");

endmodule

/* rtl/htd_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
